// ===== rtl/array_list_engine_defines.svh =====
// Assertion macros used by the checker file of the list engine.
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ALE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array_list_engine check failed");

// Next-cycle implication.
`define ALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array_list_engine check failed");

`endif

// ===== rtl/ale_pkg.sv =====
package ale_pkg;

    typedef enum logic [2:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_POP_BACK   = 3'd1,
        KIND_PUSH_FRONT = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_INSERT     = 3'd4,
        KIND_ERASE      = 3'd5,
        KIND_FIND       = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned COUNT_W = 9;

endpackage

// ===== rtl/ale_ram.sv =====
module ale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/array_list_engine.sv =====
// Ordered list of signed 32-bit words held in one RAM with a write port and a
// registered read port. An operation starts when start is high while busy is
// low; its result shows on status, found_index and count for exactly one cycle
// with done high, and must be taken then, since the receiver cannot stall.
// Push back, pop back, the error cases, and a pop front or erase that moves
// nothing, finish without going busy (done follows the accepting edge).
// Insert, erase and the front operations move one element per cycle through
// the RAM: the moves are followed by a drain state that writes the last word
// moved, and insert and push front then write the new element in a put
// state. A push front onto an empty list goes straight to that put state.
// Find does each probe of the binary search as a read, then a compare; on an
// empty list it ends in the probe state with status not found. Done follows
// the last busy cycle. Reset needs no clearing pass; the list is empty right
// after reset.
module array_list_engine
    import ale_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          kind,
    input  logic [POS_W-1:0]    position,
    input  logic signed [31:0]  value,
    output logic                done,
    output logic [2:0]          status,
    output logic [POS_W-1:0]    found_index,
    output logic [COUNT_W-1:0]  count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DOWN,
        S_DRAIN,
        S_PUT,
        S_PROBE,
        S_CMP
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        end_reg, end_next;
    logic                 put_reg, put_next;
    logic                 wpend_reg, wpend_next;
    logic [AW-1:0]        waddr_reg, waddr_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic signed [31:0]   val_reg, val_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [POS_W-1:0]     found_reg, found_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic [PW-1:0]        pos_w;
    logic [PW-1:0]        cnt_w;
    logic                 bad_pos;
    logic                 is_full;
    logic                 is_empty;
    logic [CW:0]          mid_sum;
    logic [AW-1:0]        mid_calc;

    ale_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_w    = PW'(position);
    assign cnt_w    = PW'(cnt_reg);
    assign bad_pos  = (pos_w == '0) || (pos_w >= cnt_w);
    assign is_full  = (cnt_reg >= CW'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = AW'(mid_sum >> 1);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        put_next    = put_reg;
        wpend_next  = 1'b0;
        waddr_next  = waddr_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        count_next  = count_reg;

        // A pending shift beat writes the word read in the previous cycle.
        ram_we    = wpend_reg;
        ram_waddr = waddr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    found_next  = '0;
                    val_next    = value;
                    unique case (kind_t'(kind))
                        KIND_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(cnt_reg);
                                ram_wdata = value;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        KIND_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                done_next = 1'b0;
                                end_next  = '0;
                                put_next  = 1'b1;
                                ptr_next  = AW'(cnt_reg - 1'b1);
                                state_next = is_empty ? S_PUT : S_UP;
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (cnt_reg == CW'(1))
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                put_next   = 1'b0;
                                ptr_next   = AW'(1);
                                end_next   = AW'(cnt_reg - 1'b1);
                                state_next = S_DOWN;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (bad_pos)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                put_next   = 1'b1;
                                end_next   = AW'(position);
                                ptr_next   = AW'(cnt_reg - 1'b1);
                                state_next = S_UP;
                            end
                        end
                        KIND_ERASE:
                        begin
                            if (bad_pos)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if ((pos_w + 1'b1) == cnt_w)
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                put_next   = 1'b0;
                                ptr_next   = AW'(position) + 1'b1;
                                end_next   = AW'(cnt_reg - 1'b1);
                                state_next = S_DOWN;
                            end
                        end
                        KIND_FIND:
                        begin
                            done_next  = 1'b0;
                            lo_next    = '0;
                            hi_next    = cnt_reg;
                            state_next = S_PROBE;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // Read slot ptr now, write it into slot ptr + 1 next cycle.
                wpend_next = 1'b1;
                waddr_next = ptr_reg + 1'b1;
                if (ptr_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            S_DOWN:
            begin
                wpend_next = 1'b1;
                waddr_next = ptr_reg - 1'b1;
                if (ptr_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (put_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cnt_next    = cnt_reg - 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = end_reg;
                ram_wdata   = val_reg;
                cnt_next    = cnt_reg + 1'b1;
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid_calc;
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
            end
            S_CMP:
            begin
                if ($signed(ram_rdata) == val_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    found_next  = POS_W'(mid_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    if ($signed(ram_rdata) > val_reg)
                    begin
                        hi_next = CW'(mid_reg);
                    end
                    else
                    begin
                        lo_next = CW'(mid_reg) + 1'b1;
                    end
                    state_next = S_PROBE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            count_next = COUNT_W'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            end_reg    <= '0;
            put_reg    <= 1'b0;
            wpend_reg  <= 1'b0;
            waddr_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            val_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            end_reg    <= end_next;
            put_reg    <= put_next;
            wpend_reg  <= wpend_next;
            waddr_reg  <= waddr_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            mid_reg    <= mid_next;
            val_reg    <= val_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            count_reg  <= count_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign count       = count_reg;

endmodule

// ===== rtl/ale_checker.sv =====
`include "array_list_engine_defines.svh"

module ale_checker
    import ale_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [2:0]          status,
    input logic [POS_W-1:0]    found_index,
    input logic [COUNT_W-1:0]  count
);

    // An accepted beat either finishes at once or keeps the engine busy.
    `ALE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

    // The engine only becomes busy because a beat was accepted.
    `ALE_ASSERT_NOW(a_busy_from_start, $rose(busy), $past(start))

    // A failed operation never reports a match position.
    `ALE_ASSERT_NOW(a_found_zero, done && (status != ST_OK), found_index == '0)

    // Empty is only reported for a list that holds nothing.
    `ALE_ASSERT_NOW(a_empty_count, done && (status == ST_EMPTY), count == '0)

endmodule

bind array_list_engine ale_checker u_ale_checker (.*);

// ===== sim/array_list_engine_tb.sv =====
`timescale 1ns / 1ps

module array_list_engine_tb;
    import ale_pkg::*;

    localparam int unsigned LIST_DEPTH = 256;
    localparam int unsigned TARGET_ITEMS = 1300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [2:0]         op;
        logic [POS_W-1:0]   pos;
        logic signed [31:0] key;
    } list_cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [POS_W-1:0]   found_index;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [2:0]          kind = '0;
    logic [POS_W-1:0]    position = '0;
    logic signed [31:0]  value = '0;
    logic                busy;
    logic                done;
    logic [2:0]          status;
    logic [POS_W-1:0]    found_index;
    logic [COUNT_W-1:0]  count;

    // Mirror of the list held by the block.
    logic signed [31:0]  list_words [LIST_DEPTH];
    int unsigned         list_len = 0;

    list_cmd_t           pending_cmds [$];
    list_result_t        expected_results [$];
    int unsigned         items_queued = 0;
    int unsigned         results_seen = 0;
    int unsigned         sent_items = 0;
    int unsigned         mismatches = 0;
    int unsigned         idle_cycles = 0;
    logic                beat_taken = 1'b0;

    array_list_engine #(.DEPTH(LIST_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .position    (position),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .count       (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [31:0] key);
        list_result_t res;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int unsigned  k;
        logic         hit;
        res.status = ST_OK;
        res.found_index = '0;
        case (op)
            KIND_PUSH_BACK:
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_words[list_len] = key;
                    list_len++;
                end
            KIND_POP_BACK:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    list_len--;
            KIND_PUSH_FRONT:
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (k = list_len; k > 0; k--)
                        list_words[k] = list_words[k-1];
                    list_words[0] = key;
                    list_len++;
                end
            KIND_POP_FRONT:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    for (k = 1; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                end
            KIND_INSERT:
                // The position check wins over the full check.
                if (pos == 0 || pos >= list_len)
                    res.status = ST_BADPOS;
                else if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (k = list_len; k > pos; k--)
                        list_words[k] = list_words[k-1];
                    list_words[pos] = key;
                    list_len++;
                end
            KIND_ERASE:
                if (pos == 0 || pos >= list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    for (k = pos + 1; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                end
            KIND_FIND:
            begin
                lo = 0;
                hi = list_len;
                hit = 1'b0;
                res.status = ST_NOTFOUND;
                while (lo < hi && !hit)
                begin
                    mid = (lo + hi) / 2;
                    if (list_words[mid] == key)
                    begin
                        hit = 1'b1;
                        res.status = ST_OK;
                        res.found_index = POS_W'(mid);
                    end
                    else if (list_words[mid] > key)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    // Driver: a new beat is offered only once the previous one was taken.
    always @(negedge clk)
    begin
        list_cmd_t cmd;
        logic      quiet;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || beat_taken)
        begin
            quiet = (sent_items >= 400 && sent_items < 600);
            if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 36))
            begin
                cmd = pending_cmds.pop_front();
                start <= 1'b1;
                kind <= cmd.op;
                position <= cmd.pos;
                value <= cmd.key;
                sent_items++;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: the result of an earlier beat is checked before a beat taken
    // at the same edge is predicted.
    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result strobe with no operation outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.status));
                    if (found_index !== want.found_index)
                        report_mismatch($sformatf("found_index got %0d want %0d",
                                                  found_index, want.found_index));
                    if (count !== want.count)
                        report_mismatch($sformatf("count got %0d want %0d",
                                                  count, want.count));
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_list_op(kind, position, value));
            beat_taken <= start && !busy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("array_list_engine verification failed");
                $finish;
            end
        end
    end

    function automatic void queue_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
                                      input logic signed [31:0] key);
        list_cmd_t cmd;
        cmd.op = op;
        cmd.pos = pos;
        cmd.key = key;
        pending_cmds.push_back(cmd);
        items_queued++;
    endfunction

    function automatic logic signed [31:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return WORD_MIN;
        else if (roll < 6)
            return WORD_MAX;
        else if (roll < 8)
            return 32'sd0;
        else if (roll < 10)
            return -32'sd1;
        return $urandom;
    endfunction

    // Mostly a valid interior index when the list has one, else any byte.
    function automatic logic [POS_W-1:0] pick_position(input int unsigned est);
        if (est >= 2 && $urandom_range(99) < 80)
            return POS_W'($urandom_range(est - 1, 1));
        return POS_W'($urandom_range(255, 0));
    endfunction

    // Keys are drawn mostly from held elements and their neighbors.
    function automatic logic signed [31:0] pick_key();
        int unsigned        roll;
        logic signed [31:0] held;
        roll = $urandom_range(99);
        if (list_len == 0 || roll >= 75)
            return pick_word();
        held = list_words[$urandom_range(list_len - 1, 0)];
        if (roll < 55)
            return held;
        else if (roll < 65)
            return held + 32'sd1;
        return held - 32'sd1;
    endfunction

    task automatic wait_drained();
        wait (results_seen == items_queued);
    endtask

    task automatic queue_mixed_ops(input int unsigned n);
        int unsigned      est;
        int unsigned      roll;
        logic [2:0]       op;
        logic [POS_W-1:0] pos;
        est = list_len;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 18)
                op = KIND_PUSH_BACK;
            else if (roll < 30)
                op = KIND_POP_BACK;
            else if (roll < 42)
                op = KIND_PUSH_FRONT;
            else if (roll < 52)
                op = KIND_POP_FRONT;
            else if (roll < 70)
                op = KIND_INSERT;
            else if (roll < 84)
                op = KIND_ERASE;
            else if (roll < 97)
                op = KIND_FIND;
            else
                op = KIND_UNUSED;
            // Keep the list short so that shifts stay cheap.
            if (est > 48 && op inside {KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT})
                op = KIND_POP_BACK;
            pos = pick_position(est);
            case (op)
                KIND_PUSH_BACK, KIND_PUSH_FRONT:
                    if (est < LIST_DEPTH)
                        est++;
                KIND_POP_BACK, KIND_POP_FRONT:
                    if (est > 0)
                        est--;
                KIND_INSERT:
                    if (pos != 0 && pos < est && est < LIST_DEPTH)
                        est++;
                KIND_ERASE:
                    if (pos != 0 && pos < est)
                        est--;
                default: ;
            endcase
            queue_cmd(op, pos, op == KIND_FIND ? pick_key() : pick_word());
        end
    endtask

    // Empties the list and refills it in ascending order so that find works.
    task automatic queue_sorted_rebuild(input int unsigned n);
        longint base;
        longint step;
        int unsigned i;
        repeat (list_len)
            queue_cmd(KIND_POP_BACK, pick_position(0), pick_word());
        if ($urandom_range(1))
            queue_cmd(KIND_POP_FRONT, pick_position(0), pick_word());
        if (n == LIST_DEPTH)
        begin
            base = -64'sd2147483648;
            step = $urandom_range(16000000, 1);
        end
        else
        begin
            base = longint'($signed($urandom)) >>> 1;
            step = $urandom_range(1 << 21, 1);
        end
        for (i = 0; i < n; i++)
            queue_cmd(KIND_PUSH_BACK, pick_position(0), 32'(base + i * step));
    endtask

    task automatic queue_finds(input int unsigned n);
        repeat (n)
            queue_cmd(KIND_FIND, pick_position(0), pick_key());
    endtask

    task automatic queue_full_list();
        queue_sorted_rebuild(LIST_DEPTH);
        queue_cmd(KIND_PUSH_BACK, 8'd0, pick_word());
        queue_cmd(KIND_PUSH_FRONT, 8'd0, pick_word());
        queue_cmd(KIND_INSERT, 8'd128, pick_word());
        queue_cmd(KIND_INSERT, 8'd0, pick_word());
        queue_cmd(KIND_INSERT, 8'd255, pick_word());
        wait_drained();
        queue_finds(12);
        queue_cmd(KIND_POP_FRONT, 8'd0, 32'sd0);
        queue_cmd(KIND_PUSH_FRONT, 8'd0, WORD_MIN);
        queue_cmd(KIND_ERASE, 8'd1, 32'sd0);
        queue_cmd(KIND_ERASE, 8'd254, 32'sd0);
    endtask

    initial
    begin
        int unsigned roll;
        int unsigned full_runs;
        full_runs = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: empty list, bad positions, unused code, extremes.
        queue_cmd(KIND_POP_BACK, 8'd0, 32'sd0);
        queue_cmd(KIND_POP_FRONT, 8'd0, 32'sd0);
        queue_cmd(KIND_FIND, 8'd0, 32'sd0);
        queue_cmd(KIND_ERASE, 8'd0, 32'sd0);
        queue_cmd(KIND_INSERT, 8'd0, 32'sd0);
        queue_cmd(KIND_UNUSED, 8'd0, 32'sd0);
        queue_cmd(KIND_PUSH_BACK, 8'd0, WORD_MIN);
        queue_cmd(KIND_PUSH_BACK, 8'd0, 32'sd0);
        queue_cmd(KIND_PUSH_BACK, 8'd0, WORD_MAX);
        queue_cmd(KIND_INSERT, 8'd1, -32'sd100);
        queue_cmd(KIND_INSERT, 8'd3, 32'sd100);
        queue_cmd(KIND_INSERT, 8'd5, 32'sd7);
        queue_cmd(KIND_INSERT, 8'd255, 32'sd7);
        queue_cmd(KIND_FIND, 8'd0, WORD_MAX);
        queue_cmd(KIND_FIND, 8'd0, WORD_MIN);
        queue_cmd(KIND_FIND, 8'd0, 32'sd0);
        queue_cmd(KIND_FIND, 8'd0, 32'sd1);
        queue_cmd(KIND_FIND, 8'd0, 32'sh7fff_fffe);
        queue_cmd(KIND_ERASE, 8'd4, 32'sd0);
        queue_cmd(KIND_ERASE, 8'd4, 32'sd0);
        queue_cmd(KIND_ERASE, 8'd255, 32'sd0);
        queue_cmd(KIND_PUSH_FRONT, 8'd0, 32'sh5555_5555);
        queue_cmd(KIND_POP_FRONT, 8'd0, 32'sd0);
        queue_cmd(KIND_POP_BACK, 8'd0, 32'sd0);
        queue_cmd(KIND_UNUSED, 8'd255, -32'sd1);

        while (items_queued < TARGET_ITEMS)
        begin
            wait_drained();
            roll = $urandom_range(99);
            if (full_runs < 2 && items_queued > 400 * (full_runs + 1))
            begin
                queue_full_list();
                full_runs++;
            end
            else if (roll < 55)
                queue_mixed_ops($urandom_range(40, 20));
            else if (roll < 72)
                queue_sorted_rebuild($urandom_range(40, 0));
            else
                queue_finds($urandom_range(30, 10));
        end

        wait_drained();
        repeat (LIST_DEPTH + 16) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0)
            $display("array_list_engine verification clean");
        else
            $display("array_list_engine verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ale_pkg.sv
rtl/ale_ram.sv
rtl/array_list_engine.sv
rtl/ale_checker.sv
sim/array_list_engine_tb.sv
